FILE: rtl/ptq_pkg.sv
// Types, constants and the service-order compare shared by the priority task queue.
package ptq_pkg;

  localparam int QueueDepth = 16;
  localparam int CountW     = $clog2(QueueDepth + 1);

  localparam logic       KindInsert   = 1'b0;
  localparam logic       KindPop      = 1'b1;
  localparam logic [1:0] StatInserted = 2'd0;
  localparam logic [1:0] StatFull     = 2'd1;
  localparam logic [1:0] StatPopped   = 2'd2;
  localparam logic [1:0] StatEmpty    = 2'd3;

  typedef struct packed {
    logic [7:0]  tag;
    logic [7:0]  prio;
    logic [31:0] time_val;
  } entry_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  task_tag;
    logic [7:0]  task_priority;
    logic [31:0] task_time;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        out_tag;
    logic [7:0]        out_priority;
    logic [31:0]       out_time;
    logic [CountW-1:0] entry_count;
    logic              head_valid;
    logic [7:0]        head_tag;
    logic [7:0]        head_priority;
  } res_t;

  // Broadcast from the control to every cell of the chain.
  typedef struct packed {
    logic   ins_en;
    logic   pop_en;
    entry_t fresh;
  } cell_cmd_t;

  // True when candidate a is served strictly before held entry b.
  function automatic logic goes_before(entry_t a, entry_t b);
    logic res;
    if (a.prio != b.prio) begin
      res = a.prio > b.prio;
    end else begin
      res = a.time_val < b.time_val;
    end
    return res;
  endfunction

endpackage

FILE: rtl/priority_task_queue.sv
// Top level of the priority task queue: control, count and the row of cells.
//
// Usage: drive req_i and raise start; the transaction is taken at a rising
// edge where start is high and busy is low. busy stays low, so a new
// insert or pop may be issued every cycle.
// An insert places the task in service order (priority high first, then
// earlier time, then insertion order); a pop removes the head task.
// Each transaction yields one result on res_o, marked by done_o for exactly
// one cycle, the cycle after the transaction is taken (throughput 1
// transaction per cycle). All slots compare against the new task in parallel
// and shift by one position in the same cycle.
// Insert into a full queue reports the full status and changes nothing; pop
// from an empty queue reports the empty status. Popped fields are zero when
// nothing is popped, head fields are zero when the queue is empty.
// Reset empties the queue and clears done_o; slot contents are not cleared.
// The receiver cannot stall, so a result must be captured when done_o is high.
module priority_task_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ptq_pkg::req_t  req_i,
  output logic           done_o,
  output ptq_pkg::res_t  res_o
);

  localparam int Depth = ptq_pkg::QueueDepth;
  localparam int CW    = ptq_pkg::CountW;

  logic [CW-1:0]      count_q, count_d;
  logic               done_q;
  ptq_pkg::res_t      res_q, res_d;
  ptq_pkg::cell_cmd_t cmd;
  ptq_pkg::entry_t    entries [Depth];
  logic [Depth-1:0]   flags;
  logic               accept, full, empty;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = count_q == CW'(Depth);
  assign empty  = count_q == '0;

  always_comb begin
    cmd.fresh.tag      = req_i.task_tag;
    cmd.fresh.prio     = req_i.task_priority;
    cmd.fresh.time_val = req_i.task_time;
    cmd.ins_en         = accept && (req_i.kind == ptq_pkg::KindInsert) && !full;
    cmd.pop_en         = accept && (req_i.kind == ptq_pkg::KindPop) && !empty;
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic            left_flag;
    ptq_pkg::entry_t left_entry, right_entry;
    if (i == 0) begin : g_first
      assign left_flag  = 1'b0;
      assign left_entry = cmd.fresh;
    end else begin : g_mid
      assign left_flag  = flags[i-1];
      assign left_entry = entries[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_body
      assign right_entry = entries[i+1];
    end
    ptq_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occ_i         (CW'(i) < count_q),
      .left_flag_i   (left_flag),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .flag_o        (flags[i]),
      .entry_o       (entries[i])
    );
  end

  always_comb begin
    ptq_pkg::entry_t head;
    count_d = count_q;
    res_d   = '0;
    head    = entries[0];
    if (req_i.kind == ptq_pkg::KindInsert) begin
      if (full) begin
        res_d.status = ptq_pkg::StatFull;
      end else begin
        res_d.status = ptq_pkg::StatInserted;
        count_d      = count_q + CW'(1);
        if (flags[0]) begin
          head = cmd.fresh;
        end
      end
    end else begin
      if (empty) begin
        res_d.status = ptq_pkg::StatEmpty;
      end else begin
        res_d.status       = ptq_pkg::StatPopped;
        res_d.out_tag      = entries[0].tag;
        res_d.out_priority = entries[0].prio;
        res_d.out_time     = entries[0].time_val;
        count_d            = count_q - CW'(1);
        head               = entries[1];
      end
    end
    res_d.entry_count = count_d;
    if (count_d != '0) begin
      res_d.head_valid    = 1'b1;
      res_d.head_tag      = head.tag;
      res_d.head_priority = head.prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: rtl/ptq_cell.sv
// One slot of the sorted shift-register queue.
module ptq_cell (
  input  logic              clk_i,
  input  ptq_pkg::cell_cmd_t cmd_i,
  input  logic              occ_i,
  input  logic              left_flag_i,
  input  ptq_pkg::entry_t   left_entry_i,
  input  ptq_pkg::entry_t   right_entry_i,
  output logic              flag_o,
  output ptq_pkg::entry_t   entry_o
);

  ptq_pkg::entry_t entry_q, entry_d;

  // An empty slot always accepts, so the flags form one step along the chain.
  assign flag_o = !occ_i || ptq_pkg::goes_before(cmd_i.fresh, entry_q);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins_en && flag_o) begin
      entry_d = left_flag_i ? left_entry_i : cmd_i.fresh;
    end else if (cmd_i.pop_en) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the priority task queue: directed table, then random traffic.
module tb_top;

  localparam int CW = ptq_pkg::CountW;

  typedef struct {
    ptq_pkg::req_t req;
    bit            typed;
    ptq_pkg::res_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  ptq_pkg::req_t req_i = '0;
  logic busy;
  logic done_o;
  ptq_pkg::res_t res_o;

  // Shadow copy of the queue, kept in service order with the head at slot zero.
  ptq_pkg::entry_t sched_slots[ptq_pkg::QueueDepth];
  int unsigned     sched_count = 0;
  ptq_pkg::res_t   expected_res[$];
  int              fail_count = 0;

  priority_task_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #200000;
    $display("priority_task_queue: mismatch");
    $finish;
  end

  function automatic bit serves_first(ptq_pkg::entry_t cand, ptq_pkg::entry_t held);
    if (cand.prio != held.prio) begin
      return cand.prio > held.prio;
    end
    return cand.time_val < held.time_val;
  endfunction

  // Applies one transaction to the shadow queue and returns the result it should give.
  task automatic update_schedule(input ptq_pkg::req_t r, output ptq_pkg::res_t e);
    ptq_pkg::entry_t fresh;
    int unsigned     pos;
    e = '0;
    if (r.kind == ptq_pkg::KindInsert) begin
      if (sched_count >= ptq_pkg::QueueDepth) begin
        e.status = ptq_pkg::StatFull;
      end else begin
        fresh = '{tag: r.task_tag, prio: r.task_priority, time_val: r.task_time};
        pos = sched_count;
        for (int i = 0; i < sched_count; i++) begin
          if (serves_first(fresh, sched_slots[i])) begin
            pos = i;
            break;
          end
        end
        for (int i = sched_count; i > pos; i--) begin
          sched_slots[i] = sched_slots[i-1];
        end
        sched_slots[pos] = fresh;
        sched_count++;
        e.status = ptq_pkg::StatInserted;
      end
    end else begin
      if (sched_count == 0) begin
        e.status = ptq_pkg::StatEmpty;
      end else begin
        e.out_tag      = sched_slots[0].tag;
        e.out_priority = sched_slots[0].prio;
        e.out_time     = sched_slots[0].time_val;
        for (int i = 1; i < sched_count; i++) begin
          sched_slots[i-1] = sched_slots[i];
        end
        sched_count--;
        e.status = ptq_pkg::StatPopped;
      end
    end
    e.entry_count = CW'(sched_count);
    if (sched_count > 0) begin
      e.head_valid    = 1'b1;
      e.head_tag      = sched_slots[0].tag;
      e.head_priority = sched_slots[0].prio;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v, got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_res.size() == 0) begin
        $error("result with no transaction pending: status 0x%0h", res_o.status);
        fail_count++;
      end else begin
        check_field("status", 32'(expected_res[0].status), 32'(res_o.status));
        check_field("out_tag", 32'(expected_res[0].out_tag), 32'(res_o.out_tag));
        check_field("out_priority", 32'(expected_res[0].out_priority),
                    32'(res_o.out_priority));
        check_field("out_time", expected_res[0].out_time, res_o.out_time);
        check_field("entry_count", 32'(expected_res[0].entry_count),
                    32'(res_o.entry_count));
        check_field("head_valid", 32'(expected_res[0].head_valid), 32'(res_o.head_valid));
        check_field("head_tag", 32'(expected_res[0].head_tag), 32'(res_o.head_tag));
        check_field("head_priority", 32'(expected_res[0].head_priority),
                    32'(res_o.head_priority));
        void'(expected_res.pop_front());
      end
    end
  end

  // Drives one transaction from the falling edge and returns at the edge that takes it.
  // A typed expectation replaces the predicted one, while the shadow queue still advances.
  task automatic issue_req(input ptq_pkg::req_t r, input bit typed, input ptq_pkg::res_t want);
    ptq_pkg::res_t pred;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
    update_schedule(r, pred);
    expected_res.push_back(typed ? want : pred);
  endtask

  task automatic idle_cycles(input int n);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  function automatic dir_row_t drow(logic kind, logic [7:0] tag, logic [7:0] prio,
                                    logic [31:0] tval, bit typed, ptq_pkg::res_t want);
    dir_row_t row;
    row.req   = '{kind: kind, task_tag: tag, task_priority: prio, task_time: tval};
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  // Random content: narrow priority and time ranges give many ties, wide ones cover every bit.
  function automatic ptq_pkg::req_t random_req(int insert_pct);
    ptq_pkg::req_t r;
    r.kind          = ($urandom_range(99) < insert_pct) ? ptq_pkg::KindInsert
                                                        : ptq_pkg::KindPop;
    r.task_tag      = 8'($urandom);
    r.task_priority = ($urandom_range(1) == 0) ? 8'($urandom_range(3) + 8'h7e)
                                               : 8'($urandom);
    r.task_time     = ($urandom_range(9) < 4) ? 32'($urandom_range(3)) : $urandom;
    return r;
  endfunction

  initial begin
    dir_row_t      rows[$];
    ptq_pkg::req_t r;
    int            insert_pct;
    int            waited;
    bit            quiet;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    rows.push_back(drow(ptq_pkg::KindPop,    8'h00, 8'h00, 32'h0, 1,
                        '{ptq_pkg::StatEmpty, 8'h00, 8'h00, 32'h0, 5'd0, 1'b0,
                          8'h00, 8'h00}));
    rows.push_back(drow(ptq_pkg::KindInsert, 8'hff, 8'hff, 32'hffffffff, 1,
                        '{ptq_pkg::StatInserted, 8'h00, 8'h00, 32'h0, 5'd1, 1'b1,
                          8'hff, 8'hff}));
    rows.push_back(drow(ptq_pkg::KindPop,    8'h00, 8'h00, 32'h0, 1,
                        '{ptq_pkg::StatPopped, 8'hff, 8'hff, 32'hffffffff, 5'd0, 1'b0,
                          8'h00, 8'h00}));
    rows.push_back(drow(ptq_pkg::KindInsert, 8'h00, 8'h00, 32'h0, 1,
                        '{ptq_pkg::StatInserted, 8'h00, 8'h00, 32'h0, 5'd1, 1'b1,
                          8'h00, 8'h00}));
    rows.push_back(drow(ptq_pkg::KindInsert, 8'h10, 8'h80, 32'd100, 0, '0));
    rows.push_back(drow(ptq_pkg::KindInsert, 8'h11, 8'h80, 32'd100, 0, '0));
    rows.push_back(drow(ptq_pkg::KindInsert, 8'h12, 8'h80, 32'd50, 0, '0));
    rows.push_back(drow(ptq_pkg::KindInsert, 8'h13, 8'h81, 32'd200, 0, '0));
    rows.push_back(drow(ptq_pkg::KindInsert, 8'h14, 8'h7f, 32'd0, 0, '0));
    rows.push_back(drow(ptq_pkg::KindInsert, 8'ha5, 8'hff, 32'd0, 0, '0));
    rows.push_back(drow(ptq_pkg::KindInsert, 8'h15, 8'h80, 32'd100, 0, '0));
    rows.push_back(drow(ptq_pkg::KindInsert, 8'h16, 8'h00, 32'hffffffff, 0, '0));
    rows.push_back(drow(ptq_pkg::KindInsert, 8'h17, 8'hff, 32'd1, 0, '0));
    rows.push_back(drow(ptq_pkg::KindInsert, 8'h18, 8'h01, 32'd0, 0, '0));
    rows.push_back(drow(ptq_pkg::KindInsert, 8'h19, 8'h80, 32'd99, 0, '0));
    rows.push_back(drow(ptq_pkg::KindInsert, 8'h1a, 8'h55, 32'haaaaaaaa, 0, '0));
    rows.push_back(drow(ptq_pkg::KindInsert, 8'h1b, 8'haa, 32'h55555555, 0, '0));
    rows.push_back(drow(ptq_pkg::KindInsert, 8'h1c, 8'hff, 32'd0, 0, '0));
    rows.push_back(drow(ptq_pkg::KindInsert, 8'h1d, 8'h80, 32'd100, 0, '0));
    // The queue is full here, so this insert is dropped and the head stays put.
    rows.push_back(drow(ptq_pkg::KindInsert, 8'hee, 8'hff, 32'd0, 1,
                        '{ptq_pkg::StatFull, 8'h00, 8'h00, 32'h0, 5'd16, 1'b1,
                          8'ha5, 8'hff}));
    repeat (4) rows.push_back(drow(ptq_pkg::KindPop, 8'h00, 8'h00, 32'h0, 0, '0));

    foreach (rows[k]) begin
      issue_req(rows[k].req, rows[k].typed, rows[k].want);
    end

    idle_cycles(1);
    while (expected_res.size() != 0) begin
      @(negedge clk_i);
    end

    for (int i = 0; i < 850; i++) begin
      // Phases alternate between filling, draining, mixed and overfilling traffic.
      case ((i / 40) % 4)
        0: begin
          insert_pct = 75;
        end
        1: begin
          insert_pct = 25;
        end
        2: begin
          insert_pct = 50;
        end
        default: begin
          insert_pct = 90;
        end
      endcase
      quiet = (i >= 300) && (i < 450);
      if (i == 200 || i == 600) begin
        idle_cycles(1);
        while (expected_res.size() != 0) begin
          @(negedge clk_i);
        end
      end else if (!quiet && $urandom_range(99) < 23) begin
        idle_cycles($urandom_range(1, 4));
      end
      r = random_req(insert_pct);
      issue_req(r, 0, '0);
    end

    idle_cycles(1);
    waited = 0;
    while (expected_res.size() != 0 && waited < 50) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (3) @(posedge clk_i);
    if (expected_res.size() != 0) begin
      $error("%0d expected results never arrived", expected_res.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("priority_task_queue: match");
    end else begin
      $display("priority_task_queue: mismatch");
    end
    $finish;
  end

endmodule
